// File: rtl/ssd_pkg.sv
// ----------------------------------------------------------------------------
// ssd_pkg
// Shared types, segment constants and the digit font for the four-digit
// seven-segment scanner.
// ----------------------------------------------------------------------------
package ssd_pkg;

   localparam int VALUE_W   = 16;
   localparam int DIGIT_W   = 4;
   localparam int NUM_DIGIT = 4;
   localparam int SEG_W     = 8;
   localparam int POS_W     = $clog2(NUM_DIGIT);

   // q / 10 == (q * RECIP_10) >> RECIP_SHIFT for every 16-bit q
   localparam logic [VALUE_W-1:0] RECIP_10    = 16'd52429;
   localparam int                 RECIP_SHIFT = 19;

   localparam logic OP_SCAN = 1'b0;
   localparam logic OP_LOAD = 1'b1;

   localparam logic MODE_DISTANCE = 1'b0;
   localparam logic MODE_PLAIN    = 1'b1;

   localparam logic [SEG_W-1:0] SEG_BLANK = 8'h00;
   localparam logic [SEG_W-1:0] SEG_C     = 8'h58;
   localparam logic [SEG_W-1:0] SEG_N     = 8'h54;

   // One transaction as it travels down the cell chain. digits fills from
   // the top: after four cells it holds thousands, hundreds, tens, units.
   typedef struct packed {
      logic                           op;
      logic [VALUE_W-1:0]             quo;
      logic [NUM_DIGIT*DIGIT_W-1:0]   digits;
   } item_type;

   function automatic logic [SEG_W-1:0] seg_font(input logic [DIGIT_W-1:0] d);
      logic [SEG_W-1:0] seg;
      unique case (d)
         4'd0:    seg = 8'h3f;
         4'd1:    seg = 8'h06;
         4'd2:    seg = 8'h5b;
         4'd3:    seg = 8'h4f;
         4'd4:    seg = 8'h66;
         4'd5:    seg = 8'h6d;
         4'd6:    seg = 8'h7d;
         4'd7:    seg = 8'h07;
         4'd8:    seg = 8'h7f;
         4'd9:    seg = 8'h6f;
         default: seg = SEG_BLANK;
      endcase
      return seg;
   endfunction

endpackage

// File: rtl/ssd_digit_cell.sv
// ----------------------------------------------------------------------------
// ssd_digit_cell
// One cell of the decimal chain: peels the low decimal digit off the running
// quotient and passes quotient / 10 and the digit list to the next cell.
// ----------------------------------------------------------------------------
module ssd_digit_cell (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  ssd_pkg::item_type in_item,
   output logic              out_valid,
   input  logic              out_ready,
   output ssd_pkg::item_type out_item
);
   import ssd_pkg::*;

   logic                 valid_ff;
   item_type             item_ff;
   item_type             item_in;
   logic [2*VALUE_W-1:0] prod;
   logic [VALUE_W-1:0]   quot;
   logic [VALUE_W-1:0]   times_ten;
   logic [VALUE_W-1:0]   rem;

   assign prod      = {{VALUE_W{1'b0}}, in_item.quo} * {{VALUE_W{1'b0}}, RECIP_10};
   assign quot      = VALUE_W'(prod >> RECIP_SHIFT);
   assign times_ten = (quot << 3) + (quot << 1);
   assign rem       = in_item.quo - times_ten;

   always_comb begin
      item_in        = in_item;
      item_in.quo    = quot;
      item_in.digits = {rem[DIGIT_W-1:0], in_item.digits[NUM_DIGIT*DIGIT_W-1:DIGIT_W]};
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_item  = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         item_ff <= item_in;
      end
   end

endmodule

// File: rtl/ssd_display.sv
// ----------------------------------------------------------------------------
// ssd_display
// Pattern store, scan position and result register. Loads build the four
// segment patterns from the decimal digits; scans present one digit.
// ----------------------------------------------------------------------------
module ssd_display (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_wr_en,
   input  logic                        csr_wr_data,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  ssd_pkg::item_type           in_item,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [ssd_pkg::SEG_W-1:0]     rsp_segments,
   output logic [ssd_pkg::NUM_DIGIT-1:0] rsp_digit_enable_n
);
   import ssd_pkg::*;

   logic                 format_mode_ff;
   logic [SEG_W-1:0]     pattern_ff [NUM_DIGIT];
   logic [SEG_W-1:0]     pattern_in [NUM_DIGIT];
   logic [POS_W-1:0]     pos_ff;
   logic                 rsp_valid_ff;
   logic [SEG_W-1:0]     seg_ff;
   logic [NUM_DIGIT-1:0] enable_n_ff;
   logic [NUM_DIGIT-1:0] enable_n_in;
   logic [DIGIT_W-1:0]   d_th, d_h, d_t, d_u;
   logic                 below_100;
   logic                 in_fire;

   assign d_th = in_item.digits[4*DIGIT_W-1:3*DIGIT_W];
   assign d_h  = in_item.digits[3*DIGIT_W-1:2*DIGIT_W];
   assign d_t  = in_item.digits[2*DIGIT_W-1:DIGIT_W];
   assign d_u  = in_item.digits[DIGIT_W-1:0];

   // leftover quotient is value / 10000
   assign below_100 = (in_item.quo == '0) && (d_th == '0) && (d_h == '0);

   always_comb begin
      if (format_mode_ff == MODE_DISTANCE && below_100) begin
         pattern_in[0] = (d_t == '0) ? SEG_BLANK : seg_font(d_t);
         pattern_in[1] = seg_font(d_u);
         pattern_in[2] = SEG_C;
         pattern_in[3] = SEG_N;
      end else begin
         pattern_in[0] = (format_mode_ff == MODE_DISTANCE && d_th == '0) ?
                         SEG_BLANK : seg_font(d_th);
         pattern_in[1] = seg_font(d_h);
         pattern_in[2] = seg_font(d_t);
         pattern_in[3] = seg_font(d_u);
      end
   end

   assign enable_n_in = ~(NUM_DIGIT'(1) << pos_ff);

   assign in_ready           = !rsp_valid_ff || rsp_ready;
   assign in_fire            = in_valid && in_ready;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_segments       = seg_ff;
   assign rsp_digit_enable_n = enable_n_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         format_mode_ff <= MODE_DISTANCE;
      end else if (csr_wr_en) begin
         format_mode_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_DIGIT; i++) begin
            pattern_ff[i] <= SEG_BLANK;
         end
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= (rsp_valid_ff && !rsp_ready) ||
                         (in_fire && in_item.op == OP_SCAN);
         if (in_fire) begin
            if (in_item.op == OP_LOAD) begin
               for (int i = 0; i < NUM_DIGIT; i++) begin
                  pattern_ff[i] <= pattern_in[i];
               end
            end else begin
               pos_ff <= pos_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_fire && in_item.op == OP_SCAN) begin
         seg_ff      <= pattern_ff[pos_ff];
         enable_n_ff <= enable_n_in;
      end
   end

`ifndef SYNTHESIS
   a_enable_onehot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $onehot(~enable_n_ff))
      else $error("digit enable is not one-hot low");

   a_scan_advances: assert property (@(posedge clock) disable iff (reset)
      (in_fire && in_item.op == OP_SCAN) |=> pos_ff == POS_W'($past(pos_ff) + 1'b1))
      else $error("scan did not advance position");

   a_load_keeps_pos: assert property (@(posedge clock) disable iff (reset)
      (in_fire && in_item.op == OP_LOAD) |=> $stable(pos_ff))
      else $error("load moved scan position");

   a_enable_matches_pos: assert property (@(posedge clock) disable iff (reset)
      (in_fire && in_item.op == OP_SCAN) |=> enable_n_ff[$past(pos_ff)] == 1'b0)
      else $error("digit enable does not match scanned position");
`endif

endmodule

// File: rtl/seven_segment_number_display_scanner.sv
// ----------------------------------------------------------------------------
// seven_segment_number_display_scanner
// Four-digit multiplexed seven-segment driver: loads turn a 16-bit value into
// four segment patterns, scans present one digit with its enable.
// ----------------------------------------------------------------------------
//  port group | direction | contents
//  req_*      | in        | valid/ready, op, value
//  rsp_*      | out       | valid/ready, segments, digit_enable_n (one per scan)
//  csr_*      | in        | wr_en, wr_data (format_mode), no wait
//
//  One transaction per cycle while the result side is not stalled; a scan
//  result is registered by the first cell at its accepting edge, then passes
//  three more cells and the result register.
//  Transactions stay in order, so a scan sees every earlier load.
//  A stalled result backs up through full stages only; empty stages still fill.
//  Reset blanks all four patterns, zeroes the position, selects distance mode.
// ----------------------------------------------------------------------------
module seven_segment_number_display_scanner (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic                          csr_wr_data,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_op,
   input  logic [ssd_pkg::VALUE_W-1:0]   req_value,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [ssd_pkg::SEG_W-1:0]     rsp_segments,
   output logic [ssd_pkg::NUM_DIGIT-1:0] rsp_digit_enable_n
);
   import ssd_pkg::*;

   logic     chain_valid [NUM_DIGIT+1];
   logic     chain_ready [NUM_DIGIT+1];
   item_type chain_item  [NUM_DIGIT+1];

   assign chain_valid[0]      = req_valid;
   assign req_ready           = chain_ready[0];
   assign chain_item[0].op     = req_op;
   assign chain_item[0].quo    = req_value;
   assign chain_item[0].digits = '0;

   for (genvar g = 0; g < NUM_DIGIT; g++) begin : g_cell
      ssd_digit_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (chain_valid[g]),
         .in_ready  (chain_ready[g]),
         .in_item   (chain_item[g]),
         .out_valid (chain_valid[g+1]),
         .out_ready (chain_ready[g+1]),
         .out_item  (chain_item[g+1])
      );
   end

   ssd_display u_display (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .in_valid           (chain_valid[NUM_DIGIT]),
      .in_ready           (chain_ready[NUM_DIGIT]),
      .in_item            (chain_item[NUM_DIGIT]),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_segments       (rsp_segments),
      .rsp_digit_enable_n (rsp_digit_enable_n)
   );

endmodule

// File: test/ssd_scan_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ssd_scan_checker
// Watches the request, result and register ports of the display scanner. It
// keeps its own copy of the four digit patterns, the scan position and the
// format mode. Each accepted scan queues the frame it should show, and each
// accepted result is compared with the oldest queued frame.
// ----------------------------------------------------------------------------
module ssd_scan_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic                          csr_wr_data,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  logic                          req_op,
   input  logic [ssd_pkg::VALUE_W-1:0]   req_value,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic [ssd_pkg::SEG_W-1:0]     rsp_segments,
   input  logic [ssd_pkg::NUM_DIGIT-1:0] rsp_digit_enable_n,
   output int                            mismatch_count,
   output int                            frames_outstanding
);
   import ssd_pkg::*;

   // glyphs for decimal digits 0..9, digit d at bits [8*d +: 8]
   localparam logic [10*SEG_W-1:0] DIGIT_GLYPHS = {
      8'h6f, 8'h7f, 8'h07, 8'h7d, 8'h6d, 8'h66, 8'h4f, 8'h5b, 8'h06, 8'h3f
   };

   typedef struct packed {
      logic [SEG_W-1:0]     segments;
      logic [NUM_DIGIT-1:0] enable_n;
   } digit_frame_type;

   digit_frame_type  frame_q [$];
   logic [SEG_W-1:0] shown_glyph [0:NUM_DIGIT-1];
   logic [POS_W-1:0] scan_pos;
   logic             format_sel;
   int               errors = 0;

   initial begin
      mismatch_count     = 0;
      frames_outstanding = 0;
   end

   function automatic logic [SEG_W-1:0] glyph_of(input int unsigned d);
      return DIGIT_GLYPHS[(d % 10)*SEG_W +: SEG_W];
   endfunction

   // convert a loaded value into the four stored patterns
   function automatic void render_value(input logic [VALUE_W-1:0] num);
      int unsigned thousands, hundreds, tens, units;
      thousands = (num / 1000) % 10;
      hundreds  = (num / 100) % 10;
      tens      = (num / 10) % 10;
      units     = num % 10;
      if (format_sel == MODE_DISTANCE && num < 100) begin
         shown_glyph[0] = (tens == 0) ? SEG_BLANK : glyph_of(tens);
         shown_glyph[1] = glyph_of(units);
         shown_glyph[2] = SEG_C;
         shown_glyph[3] = SEG_N;
      end else begin
         // distance mode blanks only a zero thousands digit
         shown_glyph[0] = (format_sel == MODE_DISTANCE && thousands == 0) ?
                          SEG_BLANK : glyph_of(thousands);
         shown_glyph[1] = glyph_of(hundreds);
         shown_glyph[2] = glyph_of(tens);
         shown_glyph[3] = glyph_of(units);
      end
   endfunction

   always @(posedge clock) begin
      digit_frame_type want;
      digit_frame_type nxt;
      if (reset) begin
         format_sel = MODE_DISTANCE;
         scan_pos   = '0;
         for (int i = 0; i < NUM_DIGIT; i++) shown_glyph[i] = SEG_BLANK;
         frame_q.delete();
      end else begin
         // results first: nothing accepted this edge can already be out
         if (rsp_valid && rsp_ready) begin
            if (frame_q.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("[%0t] unexpected scan result: segments %02h enable_n %b",
                           $time, rsp_segments, rsp_digit_enable_n);
            end else begin
               want = frame_q.pop_front();
               if (rsp_segments !== want.segments ||
                   rsp_digit_enable_n !== want.enable_n) begin
                  errors++;
                  if (errors <= 10)
                     $display("[%0t] scan mismatch: segments exp %02h got %02h, %s%b got %b",
                              $time, want.segments, rsp_segments, "enable_n exp ",
                              want.enable_n, rsp_digit_enable_n);
               end
            end
         end
         if (req_valid && req_ready) begin
            if (req_op == OP_LOAD) begin
               render_value(req_value);
            end else begin
               nxt.segments = shown_glyph[scan_pos];
               nxt.enable_n = ~(4'b0001 << scan_pos);
               frame_q.push_back(nxt);
               scan_pos = scan_pos + 1'b1;
            end
         end
         // mode only matters at the next load; stored patterns stay
         if (csr_wr_en) format_sel = csr_wr_data;
      end
      frames_outstanding <= frame_q.size();
      mismatch_count     <= errors;
   end

endmodule

// File: test/tb_seven_segment_number_display_scanner.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_seven_segment_number_display_scanner
// Drives loads and scan ticks into the display scanner in bursts, stalls the
// result side on a changing pattern and switches the format mode between
// phases while the block is idle. Checking is done by ssd_scan_checker.
// ----------------------------------------------------------------------------
module tb_seven_segment_number_display_scanner;
   import ssd_pkg::*;

   logic                 clock       = 1'b0;
   logic                 reset       = 1'b1;
   logic                 csr_wr_en   = 1'b0;
   logic                 csr_wr_data = 1'b0;
   logic                 req_valid   = 1'b0;
   logic                 req_ready;
   logic                 req_op      = OP_SCAN;
   logic [VALUE_W-1:0]   req_value   = '0;
   logic                 rsp_valid;
   logic                 rsp_ready   = 1'b0;
   logic [SEG_W-1:0]     rsp_segments;
   logic [NUM_DIGIT-1:0] rsp_digit_enable_n;

   int mismatch_count;
   int frames_outstanding;
   int burst_left  = 0;
   int stall_style = 0;
   int stall_age   = 0;
   int tick        = 0;

   seven_segment_number_display_scanner dut (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_op             (req_op),
      .req_value          (req_value),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_segments       (rsp_segments),
      .rsp_digit_enable_n (rsp_digit_enable_n)
   );

   ssd_scan_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_op             (req_op),
      .req_value          (req_value),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_segments       (rsp_segments),
      .rsp_digit_enable_n (rsp_digit_enable_n),
      .mismatch_count     (mismatch_count),
      .frames_outstanding (frames_outstanding)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // result side: a randomly chosen stall style, picked anew when its age runs out
   always @(posedge clock) begin
      tick++;
      if (stall_age == 0) begin
         stall_style = $urandom_range(0, 3);
         stall_age   = $urandom_range(20, 120);
      end else begin
         stall_age--;
      end
      case (stall_style)
         0:       rsp_ready <= 1'b1;
         1:       rsp_ready <= ($urandom_range(0, 1) == 1);
         2:       rsp_ready <= ($urandom_range(0, 3) == 0);
         default: rsp_ready <= (tick % 5) > 1;
      endcase
   end

   // one transaction; valid stays up inside a burst, drops for the gaps
   task automatic send_txn(input logic op, input logic [VALUE_W-1:0] num);
      req_valid <= 1'b1;
      req_op    <= op;
      req_value <= num;
      do @(posedge clock); while (!req_ready);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                  : $urandom_range(0, 10);
      end
   endtask

   task automatic scan_round();
      repeat (NUM_DIGIT) send_txn(OP_SCAN, VALUE_W'($urandom));
   endtask

   // wait until all frames are back and loads have left the pipeline
   task automatic settle();
      if (req_valid) req_valid <= 1'b0;
      do @(posedge clock); while (frames_outstanding != 0);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_mode(input logic mode);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= mode;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   function automatic logic [VALUE_W-1:0] pick_value();
      case ($urandom_range(0, 5))
         0:       return VALUE_W'($urandom_range(0, 99));
         1:       return VALUE_W'($urandom_range(100, 999));
         2:       return VALUE_W'($urandom_range(1000, 9999));
         3:       return VALUE_W'($urandom_range(10000, 65535));
         // zero thousands digit above 10000
         4:       return VALUE_W'($urandom_range(1, 6) * 10000 + $urandom_range(0, 999));
         default: return VALUE_W'($urandom);
      endcase
   endfunction

   task automatic run_phase(input logic mode, input int count);
      settle();
      write_mode(mode);
      repeat (count) begin
         if ($urandom_range(0, 3) == 0) send_txn(OP_LOAD, pick_value());
         else                           send_txn(OP_SCAN, VALUE_W'($urandom));
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      write_mode(MODE_DISTANCE);

      // blank display after reset, then distance-mode corners
      send_txn(OP_SCAN, 16'h0000);
      send_txn(OP_LOAD, 16'd0);
      scan_round();
      send_txn(OP_LOAD, 16'd100);
      scan_round();
      send_txn(OP_LOAD, 16'hffff);
      scan_round();
      settle();
      write_mode(MODE_PLAIN);
      send_txn(OP_LOAD, 16'd0);
      scan_round();

      run_phase(MODE_DISTANCE, 285);
      run_phase(MODE_PLAIN, 285);
      run_phase(MODE_DISTANCE, 285);
      run_phase(MODE_PLAIN, 285);
      settle();

      if (mismatch_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      #4_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// File: seven_segment_number_display_scanner.f
rtl/ssd_pkg.sv
rtl/ssd_digit_cell.sv
rtl/ssd_display.sv
rtl/seven_segment_number_display_scanner.sv
test/ssd_scan_checker.sv
test/tb_seven_segment_number_display_scanner.sv
